### rtl/core/vcsd_pkg.sv
// Shared types and constants for the vector command stream decoder.
package vcsd_pkg;

   // Default coordinate field width inside an XY word.
   localparam int COORD_BITS_DEFAULT = 12;
   // Width of the signed coordinates on the result channel.
   localparam int OUT_COORD_BITS = 12;

   // Result queue geometry.
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_CNT_BITS = 3;

   // Command word headers, bits 31..29.
   localparam logic [2:0] HDR_COMPLETE = 3'd0;
   localparam logic [2:0] HDR_RGB      = 3'd1;
   localparam logic [2:0] HDR_XY       = 3'd2;
   localparam logic [2:0] HDR_CMD      = 3'd5;
   localparam logic [2:0] HDR_RESYNC   = 3'd6;
   localparam logic [2:0] HDR_EXIT     = 3'd7;

   // Special byte and word values.
   localparam logic [7:0]  RESYNC_BYTE = 8'hc3;
   localparam logic [31:0] RESYNC_WORD = 32'hc0c1c2c3;
   localparam logic [7:0]  INFO_QUERY  = 8'h01;

   // Kinds of result.
   typedef enum logic [2:0] {
      KIND_BEGIN = 3'd0,
      KIND_MOVE  = 3'd1,
      KIND_LINE  = 3'd2,
      KIND_END   = 3'd3,
      KIND_EXIT  = 3'd4,
      KIND_INFO  = 3'd5
   } cmd_kind_type;

   // One input request.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       restart;
   } req_type;

   // One result.
   typedef struct packed {
      cmd_kind_type                     cmd_kind;
      logic signed [OUT_COORD_BITS-1:0] x;
      logic signed [OUT_COORD_BITS-1:0] y;
      logic [7:0]                       red;
      logic [7:0]                       green;
      logic [7:0]                       blue;
      logic [31:0]                      echo_word;
      logic [15:0]                      info_length;
      logic                             last;
   } rsp_type;

endpackage

### rtl/core/vcsd_decode.sv
// Byte assembly, decoder state and per-word command decode.
module vcsd_decode #(
   parameter int COORD_BITS = vcsd_pkg::COORD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  vcsd_pkg::req_type req,
   input  logic [15:0]       reply_length,
   output logic [1:0]        push_n,
   output vcsd_pkg::rsp_type res0,
   output vcsd_pkg::rsp_type res1
);

   logic [31:0] word_ff, word_in;
   logic [1:0]  pos_ff, pos_in;
   logic        resync_ff, resync_in;
   logic        frame_ff, frame_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic [31:0] word_next;
   logic [COORD_BITS-1:0] x_raw, y_raw;
   logic signed [COORD_BITS-1:0] x_off, y_off;
   logic signed [31:0] x_wide, y_wide;

   vcsd_pkg::rsp_type idle_r, main_r;
   logic lead_begin, main_hit;

   // Word as it stands once the incoming byte is shifted in.
   assign word_next = {word_ff[23:0], req.rx_byte};

   // Offset binary coordinates become two's complement by inverting the MSB.
   assign x_raw  = word_next[14 +: COORD_BITS];
   assign y_raw  = word_next[0 +: COORD_BITS];
   assign x_off  = {~x_raw[COORD_BITS-1], x_raw[COORD_BITS-2:0]};
   assign y_off  = {~y_raw[COORD_BITS-1], y_raw[COORD_BITS-2:0]};
   assign x_wide = 32'(x_off);
   assign y_wide = 32'(y_off);

   // Next state and the results of this byte.
   always_comb begin
      idle_r      = '0;
      idle_r.cmd_kind = vcsd_pkg::KIND_BEGIN;
      main_r      = idle_r;
      lead_begin  = 1'b0;
      main_hit    = 1'b0;
      word_in     = word_ff;
      pos_in      = pos_ff;
      resync_in   = resync_ff;
      frame_in    = frame_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;

      if (accept) begin
         if (req.restart) begin
            pos_in = 2'd0;
         end else if (resync_ff && req.rx_byte == vcsd_pkg::RESYNC_BYTE) begin
            resync_in = 1'b0;
         end else begin
            word_in = word_next;
            if (pos_ff != 2'd3) begin
               pos_in = 2'(pos_ff + 2'd1);
            end else begin
               pos_in = 2'd0;
               case (word_next[31:29])
                  vcsd_pkg::HDR_RESYNC: begin
                     if (word_next != vcsd_pkg::RESYNC_WORD) resync_in = 1'b1;
                  end
                  vcsd_pkg::HDR_XY: begin
                     lead_begin = frame_ff;
                     frame_in   = 1'b0;
                     main_hit   = 1'b1;
                     main_r.x   = x_wide[vcsd_pkg::OUT_COORD_BITS-1:0];
                     main_r.y   = y_wide[vcsd_pkg::OUT_COORD_BITS-1:0];
                     if (word_next[28] || (red_ff == 8'd0 && green_ff == 8'd0 &&
                                           blue_ff == 8'd0)) begin
                        main_r.cmd_kind = vcsd_pkg::KIND_MOVE;
                     end else begin
                        main_r.cmd_kind = vcsd_pkg::KIND_LINE;
                        main_r.red      = red_ff;
                        main_r.green    = green_ff;
                        main_r.blue     = blue_ff;
                     end
                  end
                  vcsd_pkg::HDR_RGB: begin
                     red_in   = word_next[23:16];
                     green_in = word_next[15:8];
                     blue_in  = word_next[7:0];
                  end
                  vcsd_pkg::HDR_COMPLETE: begin
                     frame_in        = 1'b1;
                     main_hit        = 1'b1;
                     main_r.cmd_kind = vcsd_pkg::KIND_END;
                  end
                  vcsd_pkg::HDR_EXIT: begin
                     main_hit        = 1'b1;
                     main_r.cmd_kind = vcsd_pkg::KIND_EXIT;
                  end
                  vcsd_pkg::HDR_CMD: begin
                     if (word_next[7:0] == vcsd_pkg::INFO_QUERY) begin
                        main_hit           = 1'b1;
                        main_r.cmd_kind    = vcsd_pkg::KIND_INFO;
                        main_r.echo_word   = word_next;
                        main_r.info_length = reply_length;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      // A frame opening goes first, ahead of the draw result.
      main_r.last = 1'b1;
      if (lead_begin) begin
         res0   = idle_r;
         res1   = main_r;
         push_n = 2'd2;
      end else begin
         res0   = main_r;
         res1   = idle_r;
         push_n = main_hit ? 2'd1 : 2'd0;
      end
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff   <= '0;
         pos_ff    <= '0;
         resync_ff <= 1'b1;
         frame_ff  <= 1'b1;
         red_ff    <= '0;
         green_ff  <= '0;
         blue_ff   <= '0;
      end else begin
         word_ff   <= word_in;
         pos_ff    <= pos_in;
         resync_ff <= resync_in;
         frame_ff  <= frame_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
      end
   end

`ifndef SYNTH
   // A pair of results is always a frame opening followed by the final draw.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd2 |-> res0.cmd_kind == vcsd_pkg::KIND_BEGIN && !res0.last && res1.last)
      else $error("result pair out of order");
   // Opening a frame clears the pending flag.
   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd2 |=> !frame_ff)
      else $error("frame still pending after begin");
   // A restart request rewinds the byte position.
   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      accept && req.restart |=> pos_ff == 2'd0)
      else $error("restart did not clear byte position");
`endif

endmodule

### rtl/core/vcsd_rsp_fifo.sv
// Result queue that takes up to two results a cycle and delivers one while rsp_stall is low.
module vcsd_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  vcsd_pkg::rsp_type push0,
   input  vcsd_pkg::rsp_type push1,
   output logic              full2,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vcsd_pkg::rsp_type rsp_payload
);

   localparam int DEPTH = vcsd_pkg::RSP_DEPTH;
   localparam int PB    = vcsd_pkg::RSP_PTR_BITS;
   localparam int CB    = vcsd_pkg::RSP_CNT_BITS;

   vcsd_pkg::rsp_type mem_ff [DEPTH];
   logic [PB-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CB-1:0] count_ff, count_in;
   logic          pop;

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = mem_ff[rd_ff];
   assign pop         = rsp_valid && !rsp_stall;
   // Stall requests unless two slots are free.
   assign full2       = count_ff > CB'(DEPTH - 2);

   // Pointer and occupancy update.
   always_comb begin
      wr_in    = PB'(wr_ff + push_n);
      rd_in    = pop ? PB'(rd_ff + 1'b1) : rd_ff;
      count_in = CB'(count_ff + {{(CB-2){1'b0}}, push_n} - {{(CB-1){1'b0}}, pop});
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ff] <= push0;
      if (push_n == 2'd2) mem_ff[PB'(wr_ff + 1'b1)] <= push1;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   // Occupancy never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(DEPTH))
      else $error("result queue overfilled");
   // Pushes only arrive while there is room for them.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> ({1'b0, count_ff} + {2'b0, push_n}) <= (CB + 1)'(DEPTH))
      else $error("push into a full result queue");
`endif

endmodule

### rtl/core/vector_command_stream_decoder_top.sv
// Top level of the vector command stream decoder.
// Takes one serial byte request per cycle and builds big-endian 32-bit command words; the
// fourth byte of a word is decoded in the cycle it is accepted and its results (none, one,
// or a frame opening followed by a move or line) enter a four-entry result queue, visible on
// the rsp_ side from the next cycle and drained one per cycle while rsp_stall is low. req_stall is raised while
// fewer than two queue slots are free, so the byte rate is set by how fast results are
// taken; with the result side never stalling, one byte is accepted every cycle. A restart
// request only rewinds the byte position. The reply length register is written through the
// csr_ port, which is always ready, and should be written only while the block is idle.
module vector_command_stream_decoder_top #(
   parameter int COORD_BITS = vcsd_pkg::COORD_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vcsd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vcsd_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   logic              accept;
   logic              full2;
   logic [1:0]        push_n;
   vcsd_pkg::rsp_type res0, res1;
   logic [15:0]       reply_length_ff, reply_length_in;

   assign req_stall = full2;
   assign accept    = req_valid && !full2;
   assign csr_ready = 1'b1;

   // Reply length register.
   assign reply_length_in = (csr_valid && csr_ready) ? csr_data : reply_length_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         reply_length_ff <= '0;
      end else begin
         reply_length_ff <= reply_length_in;
      end
   end

   vcsd_decode #(
      .COORD_BITS(COORD_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .reply_length(reply_length_ff),
      .push_n      (push_n),
      .res0        (res0),
      .res1        (res1)
   );

   vcsd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push0      (res0),
      .push1      (res1),
      .full2      (full2),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

### test/vector_command_stream_decoder_top_tb.sv
// Self-checking testbench for the vector command stream decoder top level.
module vector_command_stream_decoder_top_tb;

   localparam int CLOCK_HALF       = 6;
   localparam int RESET_CYCLES     = 12;
   localparam int DRAIN_CYCLES     = 4;
   localparam int NUM_PHASES       = 8;
   localparam int RANDOM_PER_PHASE = 135;
   localparam int COORD_W          = vcsd_pkg::COORD_BITS_DEFAULT;
   localparam int COORD_OFFSET     = 1 << (COORD_W - 1);

   // Headers that the decoder ignores; the package names only the decoded ones.
   localparam logic [2:0] HDR_UNUSED = 3'd3;
   localparam logic [2:0] HDR_FRAME  = 3'd4;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   vcsd_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   vcsd_pkg::rsp_type rsp_payload;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_data    = '0;

   // Stimulus and expectation stores.
   vcsd_pkg::req_type pending_bytes[$];
   vcsd_pkg::rsp_type expected_cmds[$];
   int          errors      = 0;
   bit          quiet_phase = 1'b0;
   int          send_gap    = 0;
   int          stall_left  = 0;

   // Shadow copy of the decoder state.
   logic [31:0] word_acc      = '0;
   int          byte_pos      = 0;
   bit          resync_armed  = 1'b1;
   bit          frame_pending = 1'b1;
   logic [7:0]  colour_r      = '0;
   logic [7:0]  colour_g      = '0;
   logic [7:0]  colour_b      = '0;
   logic [15:0] reply_len     = '0;

   vector_command_stream_decoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet_phase || pick < 55) begin
         return 0;
      end
      if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic vcsd_pkg::rsp_type plain_cmd(input vcsd_pkg::cmd_kind_type kind);
      vcsd_pkg::rsp_type cmd;
      cmd = '0;
      cmd.cmd_kind = kind;
      return cmd;
   endfunction

   // Predict the commands caused by one accepted request.
   function automatic void decode_byte(input vcsd_pkg::req_type rq);
      vcsd_pkg::rsp_type cmds[$];
      vcsd_pkg::rsp_type cmd;
      logic [11:0] xc;
      logic [11:0] yc;
      if (rq.restart) begin
         byte_pos = 0;
         return;
      end
      if (resync_armed && rq.rx_byte == vcsd_pkg::RESYNC_BYTE) begin
         resync_armed = 1'b0;
         return;
      end
      word_acc = {word_acc[23:0], rq.rx_byte};
      if (byte_pos < 3) begin
         byte_pos++;
         return;
      end
      byte_pos = 0;
      xc = 12'(word_acc[14 +: COORD_W] - COORD_OFFSET);
      yc = 12'(word_acc[0 +: COORD_W] - COORD_OFFSET);
      case (word_acc[31:29])
         vcsd_pkg::HDR_RESYNC: begin
            if (word_acc != vcsd_pkg::RESYNC_WORD) begin
               resync_armed = 1'b1;
            end
         end
         vcsd_pkg::HDR_XY: begin
            if (frame_pending) begin
               frame_pending = 1'b0;
               cmds.push_back(plain_cmd(vcsd_pkg::KIND_BEGIN));
            end
            cmd = plain_cmd(vcsd_pkg::KIND_MOVE);
            cmd.x = xc;
            cmd.y = yc;
            // A blanked or black vector only moves the beam.
            if (!word_acc[28] && {colour_r, colour_g, colour_b} != '0) begin
               cmd.cmd_kind = vcsd_pkg::KIND_LINE;
               cmd.red      = colour_r;
               cmd.green    = colour_g;
               cmd.blue     = colour_b;
            end
            cmds.push_back(cmd);
         end
         vcsd_pkg::HDR_RGB: begin
            colour_r = word_acc[23:16];
            colour_g = word_acc[15:8];
            colour_b = word_acc[7:0];
         end
         vcsd_pkg::HDR_COMPLETE: begin
            frame_pending = 1'b1;
            cmds.push_back(plain_cmd(vcsd_pkg::KIND_END));
         end
         vcsd_pkg::HDR_EXIT: begin
            cmds.push_back(plain_cmd(vcsd_pkg::KIND_EXIT));
         end
         vcsd_pkg::HDR_CMD: begin
            if (word_acc[7:0] == vcsd_pkg::INFO_QUERY) begin
               cmd = plain_cmd(vcsd_pkg::KIND_INFO);
               cmd.echo_word   = word_acc;
               cmd.info_length = reply_len;
               cmds.push_back(cmd);
            end
         end
         default: begin
         end
      endcase
      if (cmds.size() > 0) begin
         cmds[cmds.size() - 1].last = 1'b1;
      end
      foreach (cmds[i]) begin
         expected_cmds.push_back(cmds[i]);
      end
   endfunction

   // Compare one accepted command with the oldest prediction.
   task automatic check_command(input vcsd_pkg::rsp_type got);
      vcsd_pkg::rsp_type want;
      if (expected_cmds.size() == 0) begin
         report_mismatch($sformatf("unexpected command kind %0d", got.cmd_kind));
         return;
      end
      want = expected_cmds.pop_front();
      if (got.cmd_kind !== want.cmd_kind)
         report_mismatch($sformatf("cmd_kind %0d, expected %0d", got.cmd_kind, want.cmd_kind));
      if (got.x !== want.x)
         report_mismatch($sformatf("x %0d, expected %0d", got.x, want.x));
      if (got.y !== want.y)
         report_mismatch($sformatf("y %0d, expected %0d", got.y, want.y));
      if (got.red !== want.red)
         report_mismatch($sformatf("red %0h, expected %0h", got.red, want.red));
      if (got.green !== want.green)
         report_mismatch($sformatf("green %0h, expected %0h", got.green, want.green));
      if (got.blue !== want.blue)
         report_mismatch($sformatf("blue %0h, expected %0h", got.blue, want.blue));
      if (got.echo_word !== want.echo_word)
         report_mismatch($sformatf("echo_word %0h, expected %0h", got.echo_word,
                                   want.echo_word));
      if (got.info_length !== want.info_length)
         report_mismatch($sformatf("info_length %0h, expected %0h", got.info_length,
                                   want.info_length));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
   endtask

   // Request driver: presents queued bytes and predicts each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_payload);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_payload <= pending_bytes.pop_front();
               req_valid   <= 1'b1;
               send_gap = idle_cycles();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks accepted commands and stalls at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_command(rsp_payload);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_cycles();
         end
      end
   end

   function automatic void push_byte(input logic [7:0] value);
      vcsd_pkg::req_type rq;
      rq.rx_byte = value;
      rq.restart = 1'b0;
      pending_bytes.push_back(rq);
   endfunction

   function automatic void push_restart(input logic [7:0] value);
      vcsd_pkg::req_type rq;
      rq.rx_byte = value;
      rq.restart = 1'b1;
      pending_bytes.push_back(rq);
   endfunction

   // Queue the leading bytes of a word, most significant first.
   function automatic void push_word(input logic [31:0] word, input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(word[31 - 8 * i -: 8]);
      end
   endfunction

   function automatic logic [11:0] corner_coord();
      case ($urandom_range(0, 3))
         0: return 12'h000;
         1: return 12'hfff;
         2: return 12'h800;
         default: return 12'h7ff;
      endcase
   endfunction

   // Draw a command word, weighted toward drawing traffic.
   function automatic logic [31:0] random_command_word();
      logic [31:0] word;
      int          pick;
      word = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         word[31:29] = vcsd_pkg::HDR_XY;
         word[28]    = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) word[25:14] = corner_coord();
         if ($urandom_range(0, 3) == 0) word[11:0] = corner_coord();
      end else if (pick < 48) begin
         word[31:29] = vcsd_pkg::HDR_RGB;
         case ($urandom_range(0, 9))
            0, 1: word[23:0] = '0;
            2: word[23:16] = '0;
            3: word[15:0] = '0;
            4: word[23:0] = 24'hffffff;
            default: begin
            end
         endcase
      end else if (pick < 58) begin
         word[31:29] = vcsd_pkg::HDR_COMPLETE;
      end else if (pick < 66) begin
         word[31:29] = vcsd_pkg::HDR_CMD;
         word[7:0]   = vcsd_pkg::INFO_QUERY;
      end else if (pick < 70) begin
         word[31:29] = vcsd_pkg::HDR_CMD;
         if (word[7:0] == vcsd_pkg::INFO_QUERY) word[7:0] = 8'h02;
      end else if (pick < 75) begin
         word[31:29] = vcsd_pkg::HDR_EXIT;
      end else if (pick < 80) begin
         word[31:29] = vcsd_pkg::HDR_RESYNC;
      end else if (pick < 83) begin
         word = vcsd_pkg::RESYNC_WORD;
      end else begin
         word[31:29] = pick[0] ? HDR_UNUSED : HDR_FRAME;
      end
      return word;
   endfunction

   // Mostly whole words, with restarts, stray bytes and cut-off words mixed in.
   function automatic void queue_random(input int count);
      int queued;
      int pick;
      int len;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if ($urandom_range(0, 9) == 0) begin
               push_restart(8'($urandom_range(0, 255)));
               queued++;
            end
            push_word(random_command_word(), 4);
            queued += 4;
         end else if (pick < 86) begin
            push_restart(8'($urandom_range(0, 255)));
            queued++;
         end else if (pick < 91) begin
            push_byte(vcsd_pkg::RESYNC_BYTE);
            queued++;
         end else if (pick < 96) begin
            push_byte(8'($urandom_range(0, 255)));
            queued++;
         end else begin
            len = $urandom_range(1, 3);
            push_word(random_command_word(), len);
            push_restart(8'($urandom_range(0, 255)));
            queued += len + 1;
         end
      end
   endfunction

   // Hold off until every request is taken and every command has come back.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_cmds.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reply_length(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      reply_len = value;
      csr_valid <= 1'b0;
   endtask

   // Sequencer: reset, then phases separated by idle register writes.
   initial begin
      logic [15:0] settings[NUM_PHASES];
      logic [31:0] opening_words[6];
      logic [31:0] rare_words[6];
      settings      = '{16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'h8000, 16'h0000,
                        16'hffff, 16'h0000};
      settings[3]   = 16'($urandom_range(0, 65535));
      settings[5]   = 16'($urandom_range(0, 65535));
      // Black move opening a frame, full colour, line, blanked move, two frame ends.
      opening_words = '{32'h40000fff, 32'h20ffffff, 32'h43ffc000, 32'h50000800,
                        32'h00000000, 32'h00000000};
      // Info query, exit, the no-op resync word and three ignored words.
      rare_words    = '{32'ha0000001, 32'he0000000, 32'hc0c1c2c3, 32'h7fffffff,
                        32'h80000000, 32'ha0000002};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_reply_length(settings[p]);
         @(negedge clock);
         quiet_phase = (p % 3 == 2);
         if (p == 0) begin
            // The first resync byte after reset is swallowed.
            push_byte(vcsd_pkg::RESYNC_BYTE);
            push_restart(8'hff);
            foreach (opening_words[i]) push_word(opening_words[i], 4);
         end else if (p == 1) begin
            foreach (rare_words[i]) push_word(rare_words[i], 4);
            // Restart in the middle of a word, then arm resync and swallow.
            push_word(32'h20120000, 2);
            push_restart(8'h00);
            push_word(32'hc0000000, 4);
            push_byte(vcsd_pkg::RESYNC_BYTE);
         end else begin
            queue_random(RANDOM_PER_PHASE);
         end
      end
      wait_idle();
      if (errors == 0) begin
         $display("vector_command_stream_decoder_top test passed");
      end else begin
         $display("vector_command_stream_decoder_top test failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10000000;
      $display("vector_command_stream_decoder_top test failed");
      $finish;
   end

endmodule
